### hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the ARP responder and cache block.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int ARPOP_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 48;

  localparam logic [ARPOP_W-1:0] ARP_REQUEST = 16'h0100;
  localparam logic [ARPOP_W-1:0] ARP_REPLY   = 16'h0200;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  typedef enum logic [1:0] {
    OP_ARP    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_LEARN  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_INSERT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               reply_valid;
    logic [ARPOP_W-1:0] reply_operation;
    logic [MAC_W-1:0]   reply_target_mac;
    logic [IP_W-1:0]    reply_target_ip;
    logic [MAC_W-1:0]   reply_sender_mac;
    logic [IP_W-1:0]    reply_sender_ip;
    logic               hit;
    logic [MAC_W-1:0]   found_mac;
    logic [1:0]         status;
  } res_t;

endpackage

### hw/rtl/arpc_if.sv
// ----------------------------------------------------------------------------
// arpc_if
// Valid/ready channels of the ARP responder: request items and result items.
// ----------------------------------------------------------------------------
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] arp_operation;
  logic [47:0] peer_mac;
  logic [31:0] peer_ip;
  logic [31:0] target_ip;

  modport source (output valid, op, arp_operation, peer_mac, peer_ip, target_ip,
                  input ready);
  modport sink   (input valid, op, arp_operation, peer_mac, peer_ip, target_ip,
                  output ready);
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic        reply_valid;
  logic [15:0] reply_operation;
  logic [47:0] reply_target_mac;
  logic [31:0] reply_target_ip;
  logic [47:0] reply_sender_mac;
  logic [31:0] reply_sender_ip;
  logic        hit;
  logic [47:0] found_mac;
  logic [1:0]  status;

  modport source (output valid, reply_valid, reply_operation, reply_target_mac,
                  reply_target_ip, reply_sender_mac, reply_sender_ip, hit,
                  found_mac, status,
                  input ready);
  modport sink   (input valid, reply_valid, reply_operation, reply_target_mac,
                  reply_target_ip, reply_sender_mac, reply_sender_ip, hit,
                  found_mac, status,
                  output ready);
endinterface

### hw/rtl/arp_responder_and_cache.sv
// ----------------------------------------------------------------------------
// arp_responder_and_cache
// ARP request responder with a small IP-to-MAC cache (lookup, learn, clear).
//
// One item is handled at a time. in_ch.ready is high only while the block is
// idle; a finished result sits in the output register while the next item is
// taken. An item goes from input transfer to result valid through the
// decode state and, for a clear or an ARP packet not meant for us, straight
// on to the response state, else through search and insert as needed, plus
// any wait for the output register to drain: the search walks the entries
// one per cycle through a single comparator behind the registered read port
// of the table memory; a learn of a pair not found adds an insert state.
// The next item can be taken from the cycle after the result is loaded.
// A table full condition is reported as status 2 and nothing is stored.
// Configuration (own_ip at index 0, own_mac at index 1) is to be written by
// the user only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module arp_responder_and_cache
  import arpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  arpc_in_if.sink              in_ch,
  arpc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               cmp_r, cmp_nxt;
  logic               cmp_last_r, cmp_last_nxt;
  res_t               res_r, res_nxt;
  res_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [IP_W-1:0]    own_ip_r;
  logic [MAC_W-1:0]   own_mac_r;

  op_t                op_r;
  logic [ARPOP_W-1:0] arp_operation_r;
  logic [MAC_W-1:0]   peer_mac_r;
  logic [IP_W-1:0]    peer_ip_r;
  logic [IP_W-1:0]    target_ip_r;

  logic [IP_W-1:0]    entry_ip_r  [TABLE_DEPTH];
  logic [MAC_W-1:0]   entry_mac_r [TABLE_DEPTH];
  logic [IP_W-1:0]    rd_ip_r;
  logic [MAC_W-1:0]   rd_mac_r;
  logic               mem_we;

  logic               in_fire;
  logic               out_fire;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r  <= '0;
      own_mac_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:  own_ip_r  <= cfg_data[IP_W-1:0];
        CFG_OWN_MAC: own_mac_r <= cfg_data[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r            <= op_t'(in_ch.op);
      arp_operation_r <= in_ch.arp_operation;
      peer_mac_r      <= in_ch.peer_mac;
      peer_ip_r       <= in_ch.peer_ip;
      target_ip_r     <= in_ch.target_ip;
    end
  end

  // table memory: one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_ip_r[cnt_r[IDX_W-1:0]]  <= peer_ip_r;
      entry_mac_r[cnt_r[IDX_W-1:0]] <= peer_mac_r;
    end
    rd_ip_r  <= entry_ip_r[idx_r[IDX_W-1:0]];
    rd_mac_r <= entry_mac_r[idx_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      cmp_r       <= 1'b0;
      cmp_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      cmp_r       <= cmp_nxt;
      cmp_last_r  <= cmp_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    cmp_nxt       = 1'b0;
    cmp_last_nxt  = 1'b0;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mem_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ST_DECODE;
        end
      end

      ST_DECODE: begin
        unique case (op_r)
          OP_ARP: begin
            if (arp_operation_r == ARP_REQUEST && target_ip_r == own_ip_r) begin
              res_nxt.reply_valid      = 1'b1;
              res_nxt.reply_operation  = ARP_REPLY;
              res_nxt.reply_target_mac = peer_mac_r;
              res_nxt.reply_target_ip  = peer_ip_r;
              res_nxt.reply_sender_mac = own_mac_r;
              res_nxt.reply_sender_ip  = own_ip_r;
              state_nxt = (cnt_r == '0) ? ST_INSERT : ST_SEARCH;
            end else begin
              state_nxt = ST_RESP;
            end
          end
          OP_LOOKUP: begin
            if (cnt_r == '0) begin
              res_nxt.status = STAT_ABSENT;
              state_nxt      = ST_RESP;
            end else begin
              state_nxt = ST_SEARCH;
            end
          end
          OP_LEARN: begin
            state_nxt = (cnt_r == '0) ? ST_INSERT : ST_SEARCH;
          end
          OP_CLEAR: begin
            cnt_nxt   = '0;
            state_nxt = ST_RESP;
          end
          default: state_nxt = ST_RESP;
        endcase
      end

      ST_SEARCH: begin
        // issue the next read while comparing the previous one
        if (idx_r < cnt_r) begin
          cmp_nxt      = 1'b1;
          cmp_last_nxt = ((idx_r + CNT_W'(1)) == cnt_r);
          idx_nxt      = idx_r + CNT_W'(1);
        end
        if (cmp_r && rd_ip_r == peer_ip_r) begin
          cmp_nxt = 1'b0;
          if (op_r == OP_LOOKUP) begin
            res_nxt.hit       = 1'b1;
            res_nxt.found_mac = rd_mac_r;
          end
          res_nxt.status = STAT_OK;
          state_nxt      = ST_RESP;
        end else if (cmp_r && cmp_last_r) begin
          cmp_nxt = 1'b0;
          if (op_r == OP_LOOKUP) begin
            res_nxt.status = STAT_ABSENT;
            state_nxt      = ST_RESP;
          end else begin
            state_nxt = ST_INSERT;
          end
        end
      end

      ST_INSERT: begin
        if (cnt_r >= CNT_W'(TABLE_DEPTH)) begin
          res_nxt.status = STAT_FULL;
        end else begin
          mem_we         = 1'b1;
          cnt_nxt        = cnt_r + CNT_W'(1);
          res_nxt.status = STAT_OK;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.reply_valid      = out_r.reply_valid;
  assign out_ch.reply_operation  = out_r.reply_operation;
  assign out_ch.reply_target_mac = out_r.reply_target_mac;
  assign out_ch.reply_target_ip  = out_r.reply_target_ip;
  assign out_ch.reply_sender_mac = out_r.reply_sender_mac;
  assign out_ch.reply_sender_ip  = out_r.reply_sender_ip;
  assign out_ch.hit              = out_r.hit;
  assign out_ch.found_mac        = out_r.found_mac;
  assign out_ch.status           = out_r.status;

  // fill count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // fill count only steps up by one or drops to empty
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CNT_W'(1)) || (cnt_r == '0))
    else $error("fill count jumped");

  // a table write never lands beyond the table depth
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (cnt_r < CNT_W'(TABLE_DEPTH)))
    else $error("write into full table");

  // a hit is always a clean lookup result
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.hit) |->
      (out_ch.status == STAT_OK) && !out_ch.reply_valid)
    else $error("hit with bad status or reply");

  // an input transfer always starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DECODE))
    else $error("sequencer did not start");

endmodule
